/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/bbla_pkg.sv */
// types, codes and constants for the battery bar led animator
// no dependencies
`default_nettype none

package bbla_pkg;

  typedef enum logic [1:0] {
    ANIM_SEARCH = 2'd0,
    ANIM_FAULT  = 2'd1,
    ANIM_LEVEL  = 2'd2,
    ANIM_FILL   = 2'd3
  } anim_t;

  // configuration register indexes
  localparam logic [1:0] CFG_FPS       = 2'd0;
  localparam logic [1:0] CFG_REFRESH   = 2'd1;
  localparam logic [1:0] CFG_STALE_AGE = 2'd2;
  localparam logic [1:0] CFG_LOW_SOC   = 2'd3;

  localparam int CfgDataWidth = 16;

  // reset values
  localparam logic [6:0]  FpsReset      = 7'd20;
  localparam logic [9:0]  RefreshReset  = 10'd50;
  localparam logic [15:0] StaleReset    = 16'd5000;
  localparam logic [6:0]  LowSocReset   = 7'd20;
  localparam logic [31:0] LastFrameReset = 32'd0 - 32'(RefreshReset);

  localparam logic [15:0] LoadingWrap = 16'd14;

  typedef struct packed {
    logic [6:0]  fps;
    logic [9:0]  refresh_ms;
    logic [15:0] stale_ms;
    logic [6:0]  low_soc;
  } cfg_t;

  typedef struct packed {
    logic [9:0]  bar;
    logic        light;
    logic [15:0] frame_index;
    logic [3:0]  frame_mod10;
  } pattern_t;

  // charge segment: percent / 10, clamped to 9
  function automatic logic [3:0] segment_of(input logic [7:0] pct);
    logic [3:0] seg;
    seg = 4'd0;
    for (int i = 1; i <= 9; i++) begin
      if (pct >= 8'(10 * i)) begin
        seg = 4'(i);
      end
    end
    return seg;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/bbla_cfg_regs.sv */
// configuration register file for the animator
// depends on bbla_pkg
`default_nettype none

module bbla_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  input  wire logic [1:0]                       cfg_index,
  input  wire logic [bbla_pkg::CfgDataWidth-1:0] cfg_data,
  output bbla_pkg::cfg_t                        cfg
);
  import bbla_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fps        <= FpsReset;
      cfg.refresh_ms <= RefreshReset;
      cfg.stale_ms   <= StaleReset;
      cfg.low_soc    <= LowSocReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FPS:       cfg.fps        <= cfg_data[6:0];
        CFG_REFRESH:   cfg.refresh_ms <= cfg_data[9:0];
        CFG_STALE_AGE: cfg.stale_ms   <= cfg_data;
        CFG_LOW_SOC:   cfg.low_soc    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bbla_pattern.sv */
// per-frame pattern logic: frame counter wrap, bar bitmap and light
// depends on bbla_pkg
`default_nettype none

module bbla_pattern (
  input  wire bbla_pkg::anim_t  anim,
  input  wire logic [15:0]      frame_index,
  input  wire logic [3:0]       frame_mod10,
  input  wire logic [6:0]       fps,
  input  wire logic [6:0]       low_soc,
  input  wire logic [7:0]       pct,
  input  wire logic [15:0]      prot,
  output bbla_pkg::pattern_t    pat
);
  import bbla_pkg::*;

  logic [3:0]  seg;
  logic [3:0]  seg1;
  logic [8:0]  charge_limit;
  logic [8:0]  fps_x5;
  logic [9:0]  fps_x10;
  logic [10:0] fps_x15;
  logic        blink;
  logic [15:0] fi;
  logic [3:0]  pos;
  logic [10:0] fill;

  always_comb begin
    seg          = segment_of(pct);
    seg1         = seg + 4'd1;
    charge_limit = 9'(seg1) + {1'b0, fps, 1'b0};
    fps_x5       = 9'(fps) * 9'd5;
    fps_x10      = {fps_x5, 1'b0};
    fps_x15      = 11'(fps) * 11'd15;
    blink        = frame_mod10 < 4'd5;
    fi           = frame_index;
    pos          = 4'd0;
    fill         = 11'd0;

    pat.light       = 1'b0;
    pat.bar         = 10'd0;
    pat.frame_mod10 = frame_mod10;

    case (anim)
      ANIM_LEVEL: begin
        pat.light = {1'b0, pct} < {2'b0, low_soc};
        fi        = 16'd0;
        pat.bar   = 10'd1 << seg;
      end
      ANIM_FILL: begin
        if (fi > 16'(charge_limit)) begin
          fi = 16'd0;
        end
        if (fi <= 16'(seg1)) begin
          fill = (11'd1 << fi[3:0]) - 11'd1;
        end else begin
          fill = (11'd1 << seg1) - 11'd1;
        end
        pat.bar = fill[9:0];
      end
      ANIM_FAULT: begin
        // blink comes from the count before the page wrap
        pat.light = blink;
        if (fi >= 16'(fps_x15)) begin
          fi = 16'd0;
        end
        if (fi < 16'(fps_x5)) begin
          pat.bar = {1'b0, blink, prot[7:0]};
        end else if (fi < 16'(fps_x10)) begin
          pat.bar = {blink, 1'b0, prot[15:8]};
        end else begin
          pat.bar = 10'd1 << seg;
        end
      end
      default: begin
        // bouncing dot between the two border leds
        if (fi >= LoadingWrap) begin
          fi = 16'd0;
        end
        pos     = (fi[3:0] < 4'd8) ? fi[3:0] + 4'd1 : 4'd15 - fi[3:0];
        pat.bar = 10'h201 | (10'd1 << pos);
      end
    endcase

    pat.frame_index = fi;
    if (fi != frame_index) begin
      pat.frame_mod10 = 4'd0;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/battery_bar_led_animator.sv */
// top level of the battery bar led animator
// depends on bbla_pkg, bbla_cfg_regs, bbla_pattern and assert_macros.svh
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | now_ms, monitor_valid, read_time_ms,
//          |                      | protection_mask, pack_current, charge_percent
//  out     | out_valid / out_stall| bar_leds, battery_light, animation
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// a poll is taken every cycle while in_stall is low; it is held in the input register,
// where the frame decision, animation choice and pattern are worked out, and a frame
// is registered from there into the output register
// polls that do not close a frame retire from the input register with no transfer
// out_stall holds the output register; a frame then waits in the input register
// and in_stall rises until the output register frees up
// synchronous reset clears control state and sets the config registers
`default_nettype none
`include "assert_macros.svh"

module battery_bar_led_animator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // poll channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [31:0]                       now_ms,
  input  wire logic                              monitor_valid,
  input  wire logic [31:0]                       read_time_ms,
  input  wire logic [15:0]                       protection_mask,
  input  wire logic signed [15:0]                pack_current,
  input  wire logic [7:0]                        charge_percent,
  // frame channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [9:0]                             bar_leds,
  output logic                                   battery_light,
  output logic [1:0]                             animation,
  // configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [bbla_pkg::CfgDataWidth-1:0] cfg_data
);
  import bbla_pkg::*;

  cfg_t     cfg;
  pattern_t pat;

  // input register
  logic        s1_valid;
  logic [31:0] s1_now;
  logic        s1_mon_valid;
  logic [31:0] s1_read_time;
  logic [15:0] s1_prot;
  logic [15:0] s1_current;
  logic [7:0]  s1_pct;

  // animation state
  logic [31:0] last_frame_time;
  logic [15:0] frame_index;
  logic [3:0]  frame_mod10;
  anim_t       last_animation;

  logic        in_take;
  logic        out_free;
  logic        frame_due;
  logic        s1_advance;
  logic        frame_take;
  logic        stale;
  anim_t       anim;
  logic [15:0] fi_inc;
  logic [3:0]  mod_inc;

  assign cfg_ready = 1'b1;

  bbla_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // frame timing and handshake
  always_comb begin
    frame_due  = (s1_now - last_frame_time) >= 32'(cfg.refresh_ms);
    out_free   = !out_valid || !out_stall;
    s1_advance = s1_valid && (!frame_due || out_free);
    frame_take = s1_advance && frame_due;
    in_stall   = s1_valid && !s1_advance;
    in_take    = in_valid && !in_stall;
  end

  // animation choice and counter advance; a change of animation restarts the count
  always_comb begin
    stale = (s1_now - s1_read_time) > 32'(cfg.stale_ms);
    if (!s1_mon_valid || stale) begin
      anim = ANIM_SEARCH;
    end else if (s1_prot != 16'd0) begin
      anim = ANIM_FAULT;
    end else if (s1_current != 16'd0 && !s1_current[15]) begin
      anim = ANIM_FILL;
    end else begin
      anim = ANIM_LEVEL;
    end

    fi_inc  = frame_index + 16'd1;
    // mod-10 shadow of the counter, restarts when the counter wraps past all ones
    if (frame_index == 16'hFFFF || frame_mod10 == 4'd9) begin
      mod_inc = 4'd0;
    end else begin
      mod_inc = frame_mod10 + 4'd1;
    end
    if (anim != last_animation) begin
      fi_inc  = 16'd0;
      mod_inc = 4'd0;
    end
  end

  bbla_pattern u_pattern (
    .anim        (anim),
    .frame_index (fi_inc),
    .frame_mod10 (mod_inc),
    .fps         (cfg.fps),
    .low_soc     (cfg.low_soc),
    .pct         (s1_pct),
    .prot        (s1_prot),
    .pat         (pat)
  );

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_now       <= now_ms;
      s1_mon_valid <= monitor_valid;
      s1_read_time <= read_time_ms;
      s1_prot      <= protection_mask;
      s1_current   <= pack_current;
      s1_pct       <= charge_percent;
    end
  end

  // animation state, updated once per frame
  always_ff @(posedge clk) begin
    if (rst) begin
      last_frame_time <= LastFrameReset;
      frame_index     <= 16'hFFFF;
      frame_mod10     <= 4'd5;
      last_animation  <= ANIM_SEARCH;
    end else if (frame_take) begin
      last_frame_time <= s1_now;
      frame_index     <= pat.frame_index;
      frame_mod10     <= pat.frame_mod10;
      last_animation  <= anim;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (frame_take) begin
      bar_leds      <= pat.bar;
      battery_light <= pat.light;
      animation     <= anim;
    end
  end

  // mod-10 shadow never leaves its range
  `ASSERT_IMPLIES(a_mod10_range, clk, rst, 1'b1, frame_mod10 <= 4'd9)
  // polls back up only behind a held frame
  `ASSERT_IMPLIES(a_stall_cause, clk, rst, in_stall, out_valid && out_stall && s1_valid)
  // no frame, no change to the frame clock
  `ASSERT_NEXT(a_time_hold, clk, rst, !frame_take, $stable(last_frame_time))
  // the loading view always lights both border leds
  `ASSERT_IMPLIES(a_loading_border, clk, rst,
                  out_valid && animation == ANIM_SEARCH, bar_leds[0] && bar_leds[9])

endmodule

`default_nettype wire
